@@ sv/tcw_pkg.sv @@
// shared constants, operation codes and result type for the text console writer
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int OP_W     = 3;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int POS_W    = 11;
	localparam int CELL_W   = CHAR_W + ATTR_W;

	localparam logic [OP_W-1:0] OP_PUT_CHAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_NEWLINE    = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;

	typedef struct packed {
		logic              done;
		logic [POS_W-1:0]  cursor_cell;
		logic [CHAR_W-1:0] read_char;
		logic [ATTR_W-1:0] read_attr;
	} res_t;

endpackage

@@ sv/tcw_screen_mem.sv @@
// screen cell memory, one write port and one registered read port
module tcw_screen_mem import tcw_pkg::*; #(
	parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] screen_q [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			screen_q[waddr] <= wdata;
		end
		rdata_q <= screen_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/tcw_ctrl.sv @@
// command sequencer: cursor, attribute, scroll and clear sweeps, memory access
module tcw_ctrl import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [POS_W-1:0]  position,
	input  logic              cfg_valid,
	input  logic [ATTR_W-1:0] cfg_data,
	output res_t              res,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic [ADDR_W-1:0] mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	localparam int CELLS   = COLUMNS * ROWS;
	localparam int CUR_W   = $clog2(CELLS + 1);
	localparam int ROW_W   = $clog2(ROWS + 1);
	localparam int NRS_W   = $clog2(CELLS + COLUMNS + 1);
	localparam int DIV_SH  = CUR_W + $clog2(COLUMNS);
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W  = CUR_W + RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((2 ** DIV_SH + COLUMNS - 1) / COLUMNS);
	localparam logic [CUR_W-1:0]   CELLS_C   = CUR_W'(CELLS);
	localparam logic [CUR_W-1:0]   LAST_ROW  = CUR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0]  LAST_IDX  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0]  COPY_END  = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ROW_W-1:0]   ROWS_C    = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0]   ROWS_M1   = ROW_W'(ROWS - 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CLR     = 3'd1;
	localparam logic [2:0] S_SCR     = 3'd2;
	localparam logic [2:0] S_SCR_END = 3'd3;
	localparam logic [2:0] S_NL      = 3'd4;
	localparam logic [2:0] S_PUT     = 3'd5;
	localparam logic [2:0] S_RD      = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] idx_q;
	logic              init_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [ATTR_W-1:0] attr_q;
	logic              wr_s1;
	res_t              res_q;

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic              pos_ok_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] idx_s1;
	logic              blank_s1;

	logic [PROD_W-1:0] row_prod;
	logic [NRS_W-1:0]  nrs;
	logic [CUR_W-1:0]  sat_pos;
	logic [CUR_W-1:0]  cursor_inc;
	logic [CUR_W-1:0]  scr_cursor;
	logic [CELL_W-1:0] blank_cell;

	assign busy       = (state_q != S_IDLE);
	assign res        = res_q;
	assign row_prod   = PROD_W'(cursor_q) * PROD_W'(RECIP);
	assign nrs        = (NRS_W'(row_q) + NRS_W'(1)) * NRS_W'(COLUMNS);
	assign sat_pos    = (32'(position) > 32'(CELLS)) ? CELLS_C : CUR_W'(position);
	assign cursor_inc = cursor_q + CUR_W'(1);
	assign scr_cursor = (op_q == OP_PUT_CHAR || row_q == ROWS_C) ? CELLS_C : LAST_ROW;
	assign blank_cell = {(init_q ? RESET_ATTR : attr_q), BLANK_CHAR};

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = blank_cell;
		mem_raddr = (state_q == S_SCR) ? ADDR_W'(idx_q + COLUMNS) : ADDR_W'(position);
		if (wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1;
			mem_wdata = blank_s1 ? blank_cell : mem_rdata;
		end else begin
			case (state_q)
				S_CLR: begin
					mem_we = 1'b1;
				end
				S_PUT: begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(cursor_q);
					mem_wdata = {attr_q, ch_q};
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			idx_q    <= '0;
			init_q   <= 1'b1;
			cursor_q <= '0;
			attr_q   <= RESET_ATTR;
			wr_s1    <= 1'b0;
			res_q    <= '0;
		end else begin
			res_q.done <= 1'b0;
			wr_s1      <= 1'b0;
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q <= '0;
						case (op)
							OP_PUT_CHAR: begin
								if (cursor_q == CELLS_C) begin
									state_q <= S_SCR;
								end else if (char_code == NEWLINE_CHAR) begin
									state_q <= S_NL;
								end else begin
									state_q <= S_PUT;
								end
							end
							OP_NEWLINE: begin
								state_q <= S_NL;
							end
							OP_CLEAR: begin
								state_q <= S_CLR;
							end
							OP_SET_CURSOR: begin
								cursor_q <= sat_pos;
								res_q    <= '{1'b1, POS_W'(sat_pos), '0, '0};
							end
							OP_READ_CELL: begin
								state_q <= S_RD;
							end
							default: begin
								res_q <= '{1'b1, POS_W'(cursor_q), '0, '0};
							end
						endcase
					end
				end
				S_CLR: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
						init_q  <= 1'b0;
						if (!init_q) begin
							cursor_q <= '0;
							res_q    <= '{1'b1, '0, '0, '0};
						end
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_SCR: begin
					wr_s1 <= 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= S_SCR_END;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_SCR_END: begin
					if (op_q == OP_PUT_CHAR && ch_q != NEWLINE_CHAR) begin
						cursor_q <= LAST_ROW;
						state_q  <= S_PUT;
					end else begin
						cursor_q <= scr_cursor;
						res_q    <= '{1'b1, POS_W'(scr_cursor), '0, '0};
						state_q  <= S_IDLE;
					end
				end
				S_NL: begin
					if (op_q == OP_NEWLINE && row_q >= ROWS_M1) begin
						state_q <= S_SCR;
					end else begin
						cursor_q <= CUR_W'(nrs);
						res_q    <= '{1'b1, POS_W'(CUR_W'(nrs)), '0, '0};
						state_q  <= S_IDLE;
					end
				end
				S_PUT: begin
					cursor_q <= cursor_inc;
					res_q    <= '{1'b1, POS_W'(cursor_inc), '0, '0};
					state_q  <= S_IDLE;
				end
				S_RD: begin
					res_q.done        <= 1'b1;
					res_q.cursor_cell <= POS_W'(cursor_q);
					res_q.read_char   <= pos_ok_q ? mem_rdata[CHAR_W-1:0] : '0;
					res_q.read_attr   <= pos_ok_q ? mem_rdata[CELL_W-1:CHAR_W] : '0;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and pipeline registers
	always_ff @(posedge clk) begin
		row_q    <= row_prod[DIV_SH +: ROW_W];
		idx_s1   <= idx_q;
		blank_s1 <= (idx_q >= COPY_END);
		if (state_q == S_IDLE && start) begin
			op_q     <= op;
			ch_q     <= char_code;
			pos_ok_q <= (32'(position) < 32'(CELLS));
		end
	end

endmodule

@@ sv/text_console_writer.sv @@
// top level of the text console writer
//
// channel   direction  transfer condition      payload
// command   in         start && !busy          op, char_code, position
// result    out        done (one cycle)        cursor_cell, read_char, read_attr
// config    in         cfg_valid && cfg_ready  cfg_data (text attribute)
//
// set cursor and unused codes: result in the cycle after the transfer
// put char, read cell, newline in a row: go through S_PUT, S_RD or S_NL, then the result is registered
// scroll walks every cell once in S_SCR, then S_SCR_END; a newline op
// passes S_NL first, and a char that follows is written in S_PUT
// clear screen: one cell write a cycle across all COLUMNS*ROWS cells
// after reset a clearing pass over all COLUMNS*ROWS cells holds busy high
// results cannot be stalled; cfg_ready is always high
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [POS_W-1:0]  position,
	output logic              done,
	output logic [POS_W-1:0]  cursor_cell,
	output logic [CHAR_W-1:0] read_char,
	output logic [ATTR_W-1:0] read_attr,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ATTR_W-1:0] cfg_data
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	res_t              res;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign cfg_ready   = 1'b1;
	assign done        = res.done;
	assign cursor_cell = res.cursor_cell;
	assign read_char   = res.read_char;
	assign read_attr   = res.read_attr;

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.ADDR_W (ADDR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.char_code(char_code),
		.position (position),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	tcw_screen_mem #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

@@ sv/tcw_checker.sv @@
// port-level checks for the text console writer, bound to the top level
module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [OP_W-1:0]   op,
	input logic [POS_W-1:0]  position,
	input logic              done,
	input logic [POS_W-1:0]  cursor_cell,
	input logic [CHAR_W-1:0] read_char,
	input logic [ATTR_W-1:0] read_attr
);

	localparam int CELLS = COLUMNS * ROWS;

	// cursor never goes past the pending-scroll position
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CELLS > 2047 || 32'(cursor_cell) <= CELLS))
		else $error("cursor past screen end");

	// a command transfer either starts work or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("command transfer without progress");

	// set cursor answers next cycle with the saturated position
	a_set_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_SET_CURSOR) |=> (done && (32'(cursor_cell) ==
			((32'($past(position)) > CELLS) ? (CELLS % 2048) : 32'($past(position))))))
		else $error("set cursor result wrong");

	// cell contents appear only in the answer to a read
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (read_char != '0 || read_attr != '0)) |->
			$past(start && !busy && op == OP_READ_CELL, 2))
		else $error("cell data outside a read");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.op         (op),
	.position   (position),
	.done       (done),
	.cursor_cell(cursor_cell),
	.read_char  (read_char),
	.read_attr  (read_attr)
);
